// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file dfr_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define AST_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed");

// Antecedent at one edge implies consequent at the next edge.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/dfr_pkg.sv =====
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared constants and types of the dimmer frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package dfr_pkg;

    // frame buffer size in bytes (8..127)
    localparam int BUFFER_BYTES = 64;

    localparam int POS_W  = 7;   // byte position in the open frame
    localparam int LEN_W  = 9;   // expected frame length, zero = no frame
    localparam int BYTE_W = 8;
    localparam int LVL_W  = 7;
    localparam int ST_W   = 2;

    localparam logic [BYTE_W-1:0] START_BYTE   = 8'hAA;
    localparam logic [LEN_W-1:0]  BASE_LENGTH  = 9'd7;
    localparam logic [LEN_W-1:0]  ACK_LIMIT    = 9'd8;
    localparam logic [POS_W-1:0]  LENGTH_INDEX = 7'd5;
    localparam logic [POS_W-1:0]  ON_INDEX     = 7'd6;
    localparam logic [POS_W-1:0]  LEVEL_INDEX  = 7'd7;
    localparam logic [POS_W-1:0]  SUM_FIRST    = 7'd2;
    localparam logic [BYTE_W-1:0] LEVEL_MAX    = 8'd100;
    localparam logic [POS_W-1:0]  BUFFER_POS   = POS_W'(BUFFER_BYTES);

    // status codes
    localparam logic [ST_W-1:0] ST_ACK      = 2'd0;
    localparam logic [ST_W-1:0] ST_STATE    = 2'd1;
    localparam logic [ST_W-1:0] ST_BADSUM   = 2'd2;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd3;

    // one frame report from the parser
    typedef struct packed {
        logic             emit;
        logic [ST_W-1:0]  status;
        logic             new_on;
        logic [LVL_W-1:0] new_level;
        logic             changed;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/dfr_parser.sv =====
// ----------------------------------------------------------------------------
// dfr_parser
// Frame state and combinational byte decode; reports at most one result per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_parser (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,      // consume i_rx_byte now
    input  wire logic [dfr_pkg::BYTE_W-1:0] i_rx_byte,
    input  wire logic                       i_cur_on,
    input  wire logic [dfr_pkg::LVL_W-1:0]  i_cur_level,
    output dfr_pkg::t_result                o_result
);

    logic [dfr_pkg::POS_W-1:0]  r_pos,      n_pos;
    logic [dfr_pkg::LEN_W-1:0]  r_exp,      n_exp;
    logic [dfr_pkg::BYTE_W-1:0] r_sum,      n_sum;
    logic [dfr_pkg::BYTE_W-1:0] r_on_byte,  n_on_byte;
    logic [dfr_pkg::BYTE_W-1:0] r_lvl_byte, n_lvl_byte;

    logic [dfr_pkg::POS_W-1:0]  pos_inc;
    logic [dfr_pkg::LEN_W-1:0]  exp_upd;
    logic [dfr_pkg::LVL_W-1:0]  lvl_clamp;
    logic                       on_flag;

    always_comb begin
        pos_inc    = r_pos + 1'b1;
        exp_upd    = (r_pos == dfr_pkg::LENGTH_INDEX) ?
                     r_exp + {1'b0, i_rx_byte} : r_exp;
        n_on_byte  = (r_pos == dfr_pkg::ON_INDEX)    ? i_rx_byte : r_on_byte;
        n_lvl_byte = (r_pos == dfr_pkg::LEVEL_INDEX) ? i_rx_byte : r_lvl_byte;
        on_flag    = (n_on_byte != '0);
        lvl_clamp  = (n_lvl_byte > dfr_pkg::LEVEL_MAX) ?
                     dfr_pkg::LVL_W'(dfr_pkg::LEVEL_MAX) : n_lvl_byte[dfr_pkg::LVL_W-1:0];
    end

    always_comb begin
        n_pos    = r_pos;
        n_exp    = r_exp;
        n_sum    = r_sum;
        o_result = '0;
        if (i_rx_byte == dfr_pkg::START_BYTE) begin
            // start byte always reopens, dropping any open frame
            n_exp = dfr_pkg::BASE_LENGTH;
            n_pos = 7'd1;
            n_sum = '0;
        end else if (r_pos == dfr_pkg::BUFFER_POS) begin
            n_pos           = '0;
            n_exp           = '0;
            n_sum           = '0;
            o_result.emit   = 1'b1;
            o_result.status = dfr_pkg::ST_OVERFLOW;
        end else if (r_exp != '0) begin
            n_pos = pos_inc;
            n_exp = exp_upd;
            if ({2'b00, pos_inc} == exp_upd) begin
                // last byte is the checksum
                n_pos         = '0;
                n_exp         = '0;
                n_sum         = '0;
                o_result.emit = 1'b1;
                if (r_sum != i_rx_byte) begin
                    o_result.status = dfr_pkg::ST_BADSUM;
                end else if (exp_upd < dfr_pkg::ACK_LIMIT) begin
                    o_result.status = dfr_pkg::ST_ACK;
                end else begin
                    o_result.status    = dfr_pkg::ST_STATE;
                    o_result.new_on    = on_flag;
                    o_result.new_level = lvl_clamp;
                    o_result.changed   = (on_flag != i_cur_on) || (lvl_clamp != i_cur_level);
                end
            end else if (r_pos >= dfr_pkg::SUM_FIRST) begin
                n_sum = r_sum + i_rx_byte;
            end
        end
        if (!i_step) begin
            o_result.emit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_exp      <= '0;
            r_sum      <= '0;
            r_on_byte  <= '0;
            r_lvl_byte <= '0;
        end else if (i_step) begin
            r_pos      <= n_pos;
            r_exp      <= n_exp;
            r_sum      <= n_sum;
            r_on_byte  <= n_on_byte;
            r_lvl_byte <= n_lvl_byte;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dimmer_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// dimmer_frame_receiver
// Parses dimmer status frames from a byte stream into frame reports.
// ----------------------------------------------------------------------------
// Takes one received byte per request on the slave stream and emits at most
// one report per byte on the master stream. A byte 0xAA opens a new frame at
// any time; bytes outside a frame are dropped. The report gives an ack, a
// state frame (on, level clamped to 100, changed vs. the host's values), a
// checksum mismatch or a buffer overflow. Throughput is one byte per cycle
// while the output side is not stalled: the byte sits in the input register
// while the parser decodes it against the frame state, and the report lands
// in the output register. Only a full output register that is not being
// drained stalls the input side.
`default_nettype none

module dimmer_frame_receiver (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave stream: received bytes
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [7:0] rx_byte, [8] current_on,
                                          // [15:9] current_level
    // master stream: frame reports
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata    // [1:0] status, [2] new_on,
                                          // [9:3] new_level, [10] changed,
                                          // [15:11] zero
);

    // input register
    logic                       r_in_valid;
    logic [dfr_pkg::BYTE_W-1:0] r_rx_byte;
    logic                       r_cur_on;
    logic [dfr_pkg::LVL_W-1:0]  r_cur_level;

    // output register
    logic             r_out_valid;
    dfr_pkg::t_result r_out;

    dfr_pkg::t_result parse_res;
    logic             out_free;
    logic             step;

    // output slot can take a new report this cycle
    assign out_free   = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_rx_byte   <= i_s_tdata[7:0];
            r_cur_on    <= i_s_tdata[8];
            r_cur_level <= i_s_tdata[15:9];
        end
    end

    dfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_rx_byte   (r_rx_byte),
        .i_cur_on    (r_cur_on),
        .i_cur_level (r_cur_level),
        .o_result    (parse_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= parse_res.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && parse_res.emit) begin
            r_out <= parse_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0_0000, r_out.changed, r_out.new_level,
                         r_out.new_on, r_out.status};

endmodule

`default_nettype wire

// ===== rtl/dfr_checker.sv =====
// ----------------------------------------------------------------------------
// dfr_checker
// Port-level checks of the dimmer frame receiver's report stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dfr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [15:0] o_m_tdata
);

    // stalled report holds
    `AST_NEXT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // only state frames carry on/level/changed
    `AST_ALWAYS(a_plain_zero, i_clk, i_rst_n,
                !o_m_tvalid || o_m_tdata[1:0] == dfr_pkg::ST_STATE || o_m_tdata[10:2] == '0)

    // level is clamped
    `AST_ALWAYS(a_level_max, i_clk, i_rst_n, !o_m_tvalid || o_m_tdata[9:3] <= 7'd100)

    // padding stays clear
    `AST_ALWAYS(a_pad_zero, i_clk, i_rst_n, !o_m_tvalid || o_m_tdata[15:11] == '0)

endmodule

bind dimmer_frame_receiver dfr_checker u_dfr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
